// ===== hdl/ssd_pkg.sv =====
// Shared constants, types and segment table for the seven-segment serial driver.
// No dependencies; every other file imports this package.
package ssd_pkg;

  localparam int DIGITS   = 4;
  localparam int SEG_BITS = 7;
  localparam int FRAME_W  = SEG_BITS + 1;
  localparam int PULSES   = FRAME_W * DIGITS;
  localparam int CNT_W    = $clog2(PULSES);
  localparam int DIG_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int VAL_W    = 14;
  localparam int SEC_W    = 7;
  localparam int MIN_W    = 7;
  localparam int DEC_W    = 4;
  localparam int RCP_W    = 16;
  localparam int RCP_SH   = 19;

  localparam logic [RCP_W-1:0] DIV10_RCP = 16'd52429;
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(PULSES - 1);
  localparam logic [DIG_W-1:0] DIG_LAST  = DIG_W'(DIGITS - 1);

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic hold_shift;
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic logic [SEG_BITS-1:0] seg_pat(input logic [DEC_W-1:0] d);
    logic [SEG_BITS-1:0] p;
    unique case (d)
      4'd0:    p = 7'h40;
      4'd1:    p = 7'h79;
      4'd2:    p = 7'h24;
      4'd3:    p = 7'h30;
      4'd4:    p = 7'h19;
      4'd5:    p = 7'h12;
      4'd6:    p = 7'h02;
      4'd7:    p = 7'h78;
      4'd8:    p = 7'h00;
      4'd9:    p = 7'h10;
      default: p = 7'h7F;
    endcase
    return p;
  endfunction

  function automatic frame_t seg_frame(input logic [DEC_W-1:0] d);
    logic [SEG_BITS-1:0] p;
    p = seg_pat(d);
    return {p, p[0]};
  endfunction

endpackage

// ===== hdl/seven_segment_serial_display_driver_top.sv =====
// Top level of the seven-segment serial display driver.
// Depends on ssd_pkg, ssd_conv and ssd_cell.
//
// Usage:
//   Input channel: drive in_action, in_seconds, in_minutes and in_number and
//   raise start; the item is taken at a clock edge where start is high and
//   busy is low. in_action 0 shows minutes:seconds, 1 shows in_number.
//   Result channel: each item yields 8 * DIGITS pulses (32 at four digits),
//   one per cycle on consecutive cycles, each marked by out_strobe for one
//   cycle. out_pulse_kind and out_last are high only on the closing latch
//   pulse. The receiver cannot stall; results are never held back.
//   The digit converter produces one digit per cycle through a single
//   reciprocal multiplier into the staged frames; the finished item is then
//   loaded into the shifting frames once the output is free.
//   Items are limited by the serial output of one bit per cycle. The next
//   item is taken while the current one streams and follows it with no gap.
//   Reset: rst_n low clears the converter and the output sequencer; no
//   pulses are produced until an item is accepted.
module seven_segment_serial_display_driver_top
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_action,
  input  logic [SEC_W-1:0] in_seconds,
  input  logic [MIN_W-1:0] in_minutes,
  input  logic [VAL_W-1:0] in_number,
  output logic             out_strobe,
  output logic             out_serial_data,
  output logic             out_pulse_kind,
  output logic             out_last
);

  logic             accept;
  logic             step;
  logic             pend;
  logic             xfer;
  logic             strm_r;
  logic             strm_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             end_pulse;
  cell_ctl_t        ctl;
  frame_t           hold_w [DIGITS+1];
  logic [DIGITS:0]  msb_w;

  assign accept    = start & ~busy;
  assign end_pulse = strm_r & (cnt_r == CNT_LAST);
  assign xfer      = pend & (~strm_r | (cnt_r == CNT_LAST));

  ssd_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .action  (in_action),
    .seconds (in_seconds),
    .minutes (in_minutes),
    .number  (in_number),
    .xfer    (xfer),
    .busy    (busy),
    .step    (step),
    .pend    (pend),
    .frame   (hold_w[DIGITS])
  );

  assign ctl.hold_shift = step;
  assign ctl.load       = xfer;
  assign ctl.shift      = strm_r;
  assign msb_w[DIGITS]  = 1'b0;

  genvar i;
  generate
    for (i = 0; i < DIGITS; i++) begin : g_cell
      ssd_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .hold_in  (hold_w[i+1]),
        .shf_in   (msb_w[i+1]),
        .hold_out (hold_w[i]),
        .shf_msb  (msb_w[i])
      );
    end
  endgenerate

  always_comb begin
    strm_nxt = strm_r;
    cnt_nxt  = cnt_r;
    if (xfer) begin
      strm_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (strm_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        strm_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strm_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      strm_r <= strm_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_strobe      = strm_r;
  assign out_serial_data = msb_w[0];
  assign out_pulse_kind  = end_pulse;
  assign out_last        = end_pulse;

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> step)
    else $error("converter did not start after accept");

  a_run_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && pend))
    else $error("converter running while holding a finished item");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    end_pulse && pend |=> strm_r && cnt_r == '0)
    else $error("gap between back-to-back items");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_pulse && !pend |=> !strm_r)
    else $error("stream ran past its latch pulse");

endmodule

// ===== hdl/ssd_cell.sv =====
// One digit cell: a staged frame and an active frame that shifts toward cell 0.
// Depends on ssd_pkg.
module ssd_cell
  import ssd_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  frame_t    hold_in,
  input  logic      shf_in,
  output frame_t    hold_out,
  output logic      shf_msb
);

  frame_t hold_r;
  frame_t shf_r;

  always_ff @(posedge clk) begin
    if (ctl.hold_shift) begin
      hold_r <= hold_in;
    end
    if (ctl.load) begin
      shf_r <= hold_r;
    end else if (ctl.shift) begin
      shf_r <= {shf_r[FRAME_W-2:0], shf_in};
    end
  end

  assign hold_out = hold_r;
  assign shf_msb  = shf_r[FRAME_W-1];

endmodule

// ===== hdl/ssd_conv.sv =====
// Digit converter: one decimal digit per cycle by reciprocal multiply, frame out.
// Depends on ssd_pkg.
module ssd_conv
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             action,
  input  logic [SEC_W-1:0] seconds,
  input  logic [MIN_W-1:0] minutes,
  input  logic [VAL_W-1:0] number,
  input  logic             xfer,
  output logic             busy,
  output logic             step,
  output logic             pend,
  output frame_t           frame
);

  logic                     act_r;
  logic                     pend_r;
  logic                     run_r;
  logic                     run_nxt;
  logic                     pend_nxt;
  logic [DIG_W-1:0]         k_r;
  logic [DIG_W-1:0]         k_nxt;
  logic [VAL_W-1:0]         val_r;
  logic [VAL_W-1:0]         val_nxt;
  logic [MIN_W-1:0]         min_r;
  logic [VAL_W+RCP_W-1:0]   prod;
  logic [VAL_W-1:0]         quo;
  logic [VAL_W-1:0]         rem;

  assign prod  = VAL_W'(0) + val_r * DIV10_RCP;
  assign quo   = VAL_W'(prod >> RCP_SH);
  assign rem   = val_r - ((quo << 3) + (quo << 1));
  assign frame = seg_frame(rem[DEC_W-1:0]);
  assign step  = run_r;
  assign pend  = pend_r;
  assign busy  = run_r | pend_r;

  always_comb begin
    run_nxt  = run_r;
    pend_nxt = pend_r;
    k_nxt    = k_r;
    val_nxt  = val_r;
    if (accept) begin
      run_nxt = 1'b1;
      k_nxt   = '0;
      val_nxt = action ? number : VAL_W'(seconds);
    end else if (run_r) begin
      k_nxt = k_r + DIG_W'(1);
      priority if (!act_r && int'(k_r) == 1) begin
        val_nxt = VAL_W'(min_r);
      end else if (!act_r && int'(k_r) == 3) begin
        val_nxt = '0;
      end else begin
        val_nxt = quo;
      end
      if (k_r == DIG_LAST) begin
        run_nxt  = 1'b0;
        pend_nxt = 1'b1;
      end
    end else if (xfer) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pend_r <= 1'b0;
      k_r    <= '0;
    end else begin
      run_r  <= run_nxt;
      pend_r <= pend_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (accept) begin
      act_r <= action;
      min_r <= minutes;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for seven_segment_serial_display_driver_top.
// Depends on ssd_pkg; a scoreboard class expands each accepted request into its
// expected serial pulses and compares them with the strobed outputs in order.
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  localparam int ITEM_COUNT  = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  localparam logic [SEG_BITS-1:0] SEG_CODES [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  typedef enum logic {
    SHOW_CLOCK  = 1'b0,
    SHOW_NUMBER = 1'b1
  } show_mode_e;

  typedef enum logic {
    PULSE_SHIFT = 1'b0,
    PULSE_LATCH = 1'b1
  } pulse_kind_e;

  typedef struct {
    show_mode_e       action;
    logic [SEC_W-1:0] seconds;
    logic [MIN_W-1:0] minutes;
    logic [VAL_W-1:0] number;
  } request_t;

  typedef struct packed {
    logic        serial_data;
    pulse_kind_e pulse_kind;
    logic        last;
  } pulse_t;

  class pulse_scoreboard;
    pulse_t pulse_q[$];
    int     mismatches;
    int     pulse_index;

    function new();
      mismatches  = 0;
      pulse_index = 0;
    endfunction

    function int pending();
      return pulse_q.size();
    endfunction

    function void note_request(request_t r);
      int unsigned value;
      int unsigned digit;
      logic [SEG_BITS-1:0] pat;
      logic level;
      level = 1'b0;
      for (int d = 0; d < DIGITS; d++) begin
        if (r.action == SHOW_NUMBER) begin
          value = r.number;
          for (int k = 0; k < d; k++) value = value / 10;
          digit = value % 10;
        end else begin
          case (d)
            0:       digit = r.seconds % 10;
            1:       digit = (r.seconds / 10) % 10;
            2:       digit = r.minutes % 10;
            3:       digit = (r.minutes / 10) % 10;
            default: digit = 0;
          endcase
        end
        pat = SEG_CODES[digit];
        for (int b = SEG_BITS; b > 0; b--) begin
          level = pat[b-1];
          pulse_q.push_back('{level, PULSE_SHIFT, 1'b0});
        end
        if (d + 1 < DIGITS) pulse_q.push_back('{level, PULSE_SHIFT, 1'b0});
        else                pulse_q.push_back('{level, PULSE_LATCH, 1'b1});
      end
    endfunction

    function void check_pulse(pulse_t got);
      pulse_t want;
      if (pulse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("pulse %0d unexpected: data=%0b kind=%0b last=%0b", pulse_index,
                   got.serial_data, got.pulse_kind, got.last);
      end else begin
        want = pulse_q.pop_front();
        if (want.serial_data !== got.serial_data || want.pulse_kind !== got.pulse_kind ||
            want.last !== got.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pulse %0d mismatch: expected data=%0b kind=%0b last=%0b, got %0b %0b %0b",
                     pulse_index, want.serial_data, want.pulse_kind, want.last,
                     got.serial_data, got.pulse_kind, got.last);
        end
      end
      pulse_index++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_action = 1'b0;
  logic [SEC_W-1:0] in_seconds = '0;
  logic [MIN_W-1:0] in_minutes = '0;
  logic [VAL_W-1:0] in_number = '0;
  logic             out_strobe;
  logic             out_serial_data;
  logic             out_pulse_kind;
  logic             out_last;

  pulse_scoreboard sb = new();
  int              cycle_count = 0;

  seven_segment_serial_display_driver_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_seconds      (in_seconds),
    .in_minutes      (in_minutes),
    .in_number       (in_number),
    .out_strobe      (out_strobe),
    .out_serial_data (out_serial_data),
    .out_pulse_kind  (out_pulse_kind),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_request('{show_mode_e'(in_action), in_seconds, in_minutes, in_number});
    if (rst_n && out_strobe)
      sb.check_pulse('{out_serial_data, pulse_kind_e'(out_pulse_kind), out_last});
  end

  task automatic send_item(request_t r);
    @(negedge clk);
    start      <= 1'b1;
    in_action  <= r.action;
    in_seconds <= r.seconds;
    in_minutes <= r.minutes;
    in_number  <= r.number;
    do @(posedge clk); while (busy);
  endtask

  task automatic go_idle(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    go_idle(0);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DIGITS + 8) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned sel;
    sel       = $urandom_range(0, 9);
    r.action  = show_mode_e'($urandom_range(0, 1));
    r.seconds = SEC_W'($urandom_range(0, 99));
    r.minutes = MIN_W'($urandom_range(0, 99));
    r.number  = VAL_W'($urandom_range(0, 9999));
    if (sel < 2) begin
      r.seconds = SEC_W'($urandom_range(0, 127));
      r.minutes = MIN_W'($urandom_range(0, 127));
      r.number  = VAL_W'($urandom_range(0, 16383));
    end
    return r;
  endfunction

  request_t directed[$];
  int       items_left;
  int       burst;

  initial begin
    directed = '{
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd0},
      '{SHOW_NUMBER, 7'd127, 7'd127, 14'd9999},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd1234},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd5678},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd9012},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd16383},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd10000},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd8},
      '{SHOW_CLOCK,  7'd0,   7'd0,   14'd16383},
      '{SHOW_CLOCK,  7'd59,  7'd59,  14'd0},
      '{SHOW_CLOCK,  7'd99,  7'd99,  14'd0},
      '{SHOW_CLOCK,  7'd127, 7'd127, 14'd0},
      '{SHOW_CLOCK,  7'd100, 7'd100, 14'd9999},
      '{SHOW_CLOCK,  7'd7,   7'd45,  14'd0},
      '{SHOW_CLOCK,  7'd36,  7'd12,  14'd0},
      '{SHOW_CLOCK,  7'd80,  7'd9,   14'd0},
      '{SHOW_CLOCK,  7'd1,   7'd0,   14'd0},
      '{SHOW_NUMBER, 7'd0,   7'd0,   14'd1}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i]);
      if (i % 4 == 3) go_idle($urandom_range(1, 40));
    end
    drain();

    items_left = ITEM_COUNT;
    while (items_left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && items_left > 0) begin
        send_item(random_request());
        burst--;
        items_left--;
      end
      if (items_left > ITEM_COUNT / 2 - 8 && items_left <= ITEM_COUNT / 2) drain();
      else if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 40));
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
